// File: sv/nsr_pkg.sv
package nsr_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int DIV_STEPS  = DATA_WIDTH + FRAC_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam int TOL_W    = 16;
   localparam int ITER_W   = 6;
   localparam int GUESS_W  = 16;
   localparam int STATUS_W = 2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_TOLERANCE      = 2'd0;
   localparam logic [1:0] REG_MAX_ITERATIONS = 2'd1;
   localparam logic [1:0] REG_MIN_GUESS      = 2'd2;

   localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(1);
   localparam logic [ITER_W-1:0]  ITER_RESET  = ITER_W'(40);
   localparam logic [GUESS_W-1:0] GUESS_RESET = GUESS_W'(1);

   localparam logic [STATUS_W-1:0] STATUS_SOLVED    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LIMITED   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_GUESS = 2'd2;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] radicand;
      logic [DATA_WIDTH-1:0] initial_guess;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] root;
      logic [STATUS_W-1:0]   status;
      logic [ITER_W-1:0]     iterations;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic [DATA_WIDTH-1:0] dividend;
      logic [DATA_WIDTH-1:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DATA_WIDTH-1:0] quotient;
   } div_stat_type;

endpackage

// File: sv/nsr_divider.sv
module nsr_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  nsr_pkg::div_ctrl_type ctrl,
   output nsr_pkg::div_stat_type stat
);

   logic [nsr_pkg::DATA_WIDTH-1:0] num_ff, num_in;
   logic [nsr_pkg::DATA_WIDTH-1:0] den_ff, den_in;
   logic [nsr_pkg::DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [nsr_pkg::DATA_WIDTH-1:0] quot_ff, quot_in;
   logic                           ovf_ff, ovf_in;
   logic                           zero_ff, zero_in;
   logic [nsr_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [nsr_pkg::DATA_WIDTH:0]   rem_shift;
   logic [nsr_pkg::DATA_WIDTH:0]   rem_sub;
   logic                           qbit;

   // The partial remainder stays below the divisor, so one extra bit is enough.
   assign rem_shift = {rem_ff, num_ff[nsr_pkg::DATA_WIDTH-1]};
   assign rem_sub   = rem_shift - {1'b0, den_ff};
   assign qbit      = (rem_shift >= {1'b0, den_ff});

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      ovf_in  = ovf_ff;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         num_in  = ctrl.dividend;
         den_in  = ctrl.divisor;
         rem_in  = '0;
         quot_in = '0;
         ovf_in  = 1'b0;
         zero_in = (ctrl.divisor == '0);
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Zeros shift in behind the dividend to supply the fraction bits.
         num_in  = {num_ff[nsr_pkg::DATA_WIDTH-2:0], 1'b0};
         rem_in  = qbit ? rem_sub[nsr_pkg::DATA_WIDTH-1:0]
                        : rem_shift[nsr_pkg::DATA_WIDTH-1:0];
         ovf_in  = ovf_ff | quot_ff[nsr_pkg::DATA_WIDTH-1];
         quot_in = {quot_ff[nsr_pkg::DATA_WIDTH-2:0], qbit};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == nsr_pkg::DIV_CNT_W'(nsr_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
   end

   assign stat.busy     = busy_ff;
   assign stat.done     = done_ff;
   assign stat.quotient = (zero_ff || ovf_ff) ? '1 : quot_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider finished without having run");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> !busy_ff)
      else $error("divider started while still busy");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |=> busy_ff && !done_ff)
      else $error("divider did not begin after start");

endmodule

// File: sv/newton_square_root.sv
// Newton-Raphson square root on unsigned Q16.16 values, one transaction at a time.
// Each Newton step runs the bit-serial divider, then forms the new estimate and then
// tests convergence; a rejected guess skips the divider and goes straight to the result,
// and the step cap is at most 63.
// req_stall stays high from acceptance until the result is in the output register.
// Synchronous reset clears the control state and loads the register defaults.
module newton_square_root (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  nsr_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output nsr_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [nsr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [nsr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [nsr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_CHECK  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [nsr_pkg::TOL_W-1:0]      tol_ff, tol_in;
   logic [nsr_pkg::ITER_W-1:0]     max_iter_ff, max_iter_in;
   logic [nsr_pkg::GUESS_W-1:0]    min_guess_ff, min_guess_in;

   logic [nsr_pkg::DATA_WIDTH-1:0] radicand_ff, radicand_in;
   logic [nsr_pkg::DATA_WIDTH-1:0] est_ff, est_in;
   logic [nsr_pkg::DATA_WIDTH-1:0] next_ff, next_in;
   logic [nsr_pkg::ITER_W-1:0]     count_ff, count_in;
   nsr_pkg::rsp_type               result_ff, result_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   nsr_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   nsr_pkg::div_ctrl_type          div_ctrl;
   nsr_pkg::div_stat_type          div_stat;

   logic                           req_take;
   logic                           csr_write;
   logic [1:0]                     csr_index;
   logic [nsr_pkg::DATA_WIDTH:0]   sum;
   logic [nsr_pkg::DATA_WIDTH-1:0] diff;
   logic                           converged;
   logic                           limited;
   logic                           out_free;

   nsr_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         nsr_pkg::REG_TOLERANCE:      csr_prdata = nsr_pkg::CSR_DATA_W'(tol_ff);
         nsr_pkg::REG_MAX_ITERATIONS: csr_prdata = nsr_pkg::CSR_DATA_W'(max_iter_ff);
         nsr_pkg::REG_MIN_GUESS:      csr_prdata = nsr_pkg::CSR_DATA_W'(min_guess_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   always_comb begin
      tol_in       = tol_ff;
      max_iter_in  = max_iter_ff;
      min_guess_in = min_guess_ff;
      if (csr_write) begin
         unique case (csr_index)
            nsr_pkg::REG_TOLERANCE:
               tol_in = csr_pwdata[nsr_pkg::TOL_W-1:0];
            nsr_pkg::REG_MAX_ITERATIONS:
               max_iter_in = csr_pwdata[nsr_pkg::ITER_W-1:0];
            nsr_pkg::REG_MIN_GUESS:
               min_guess_in = csr_pwdata[nsr_pkg::GUESS_W-1:0];
            default: ;
         endcase
      end
   end

   // The sum saturates before halving, so the new estimate never wraps.
   assign sum  = {1'b0, est_ff} + {1'b0, div_stat.quotient};
   assign diff = (next_ff >= est_ff) ? (next_ff - est_ff) : (est_ff - next_ff);
   assign converged = (diff <= nsr_pkg::DATA_WIDTH'(tol_ff));
   assign limited   = (count_ff >= max_iter_ff);

   always_comb begin
      div_ctrl.start    = 1'b0;
      div_ctrl.dividend = (state_ff == ST_IDLE) ? req_data.radicand : radicand_ff;
      div_ctrl.divisor  = (state_ff == ST_IDLE) ? req_data.initial_guess : next_ff;

      state_in     = state_ff;
      radicand_in  = radicand_ff;
      est_in       = est_ff;
      next_in      = next_ff;
      count_in     = count_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               radicand_in = req_data.radicand;
               est_in      = req_data.initial_guess;
               count_in    = '0;
               if (req_data.initial_guess < nsr_pkg::DATA_WIDTH'(min_guess_ff)) begin
                  result_in.root       = '0;
                  result_in.status     = nsr_pkg::STATUS_BAD_GUESS;
                  result_in.iterations = '0;
                  state_in             = ST_FINISH;
               end else begin
                  div_ctrl.start = 1'b1;
                  state_in       = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               // A saturated sum is all ones, so half of it keeps the top bit clear.
               next_in  = sum[nsr_pkg::DATA_WIDTH] ? {1'b0, {(nsr_pkg::DATA_WIDTH-1){1'b1}}}
                                                   : sum[nsr_pkg::DATA_WIDTH:1];
               count_in = count_ff + 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (converged || limited) begin
               result_in.root       = next_ff;
               result_in.status     = limited ? nsr_pkg::STATUS_LIMITED
                                              : nsr_pkg::STATUS_SOLVED;
               result_in.iterations = count_ff;
               state_in             = ST_FINISH;
            end else begin
               est_in         = next_ff;
               div_ctrl.start = 1'b1;
               state_in       = ST_DIVIDE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tol_ff       <= nsr_pkg::TOL_RESET;
         max_iter_ff  <= nsr_pkg::ITER_RESET;
         min_guess_ff <= nsr_pkg::GUESS_RESET;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tol_ff       <= tol_in;
         max_iter_ff  <= max_iter_in;
         min_guess_ff <= min_guess_in;
         count_ff     <= count_in;
      end
      radicand_ff <= radicand_in;
      est_ff      <= est_in;
      next_ff     <= next_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_bad_guess_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == nsr_pkg::STATUS_BAD_GUESS
         |-> rsp_data_ff.root == '0 && rsp_data_ff.iterations == '0)
      else $error("rejected guess reported a root or a step count");

   a_steps_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != nsr_pkg::STATUS_BAD_GUESS
         |-> rsp_data_ff.iterations != '0)
      else $error("result reported without any Newton step");

   a_divider_idle_outside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_FINISH) |-> !div_stat.busy)
      else $error("divider busy while no transaction is in progress");

   a_check_after_divide: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |-> $past(div_stat.done))
      else $error("convergence tested before the quotient was ready");

endmodule

// File: sim/newton_square_root_tb.sv
module newton_square_root_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 8_000_000;
   localparam int HOLD_CYCLES  = 600;

   class sqrt_scoreboard;
      nsr_pkg::rsp_type                     expected_roots[$];
      logic [nsr_pkg::TOL_W-1:0]            tolerance;
      logic [nsr_pkg::ITER_W-1:0]           iteration_cap;
      logic [nsr_pkg::GUESS_W-1:0]          guess_floor;
      int                                   errors;
      int                                   results_seen;
      int                                   solved_seen;
      int                                   limited_seen;
      int                                   rejected_seen;

      function new();
         tolerance     = nsr_pkg::TOL_RESET;
         iteration_cap = nsr_pkg::ITER_RESET;
         guess_floor   = nsr_pkg::GUESS_RESET;
      endfunction

      function void write_register(logic [1:0] index,
                                   logic [nsr_pkg::CSR_DATA_W-1:0] value);
         case (index)
            nsr_pkg::REG_TOLERANCE:      tolerance     = value[nsr_pkg::TOL_W-1:0];
            nsr_pkg::REG_MAX_ITERATIONS: iteration_cap = value[nsr_pkg::ITER_W-1:0];
            nsr_pkg::REG_MIN_GUESS:      guess_floor   = value[nsr_pkg::GUESS_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [nsr_pkg::CSR_DATA_W-1:0] register_value(logic [1:0] index);
         case (index)
            nsr_pkg::REG_TOLERANCE:      return nsr_pkg::CSR_DATA_W'(tolerance);
            nsr_pkg::REG_MAX_ITERATIONS: return nsr_pkg::CSR_DATA_W'(iteration_cap);
            nsr_pkg::REG_MIN_GUESS:      return nsr_pkg::CSR_DATA_W'(guess_floor);
            default:                     return '0;
         endcase
      endfunction

      // Floor of n * 2^FRAC_BITS / d; a zero divisor or an oversized quotient gives all ones.
      function logic [nsr_pkg::DATA_WIDTH-1:0] scaled_quotient(
         logic [nsr_pkg::DATA_WIDTH-1:0] n,
         logic [nsr_pkg::DATA_WIDTH-1:0] d);
         logic [2*nsr_pkg::DATA_WIDTH-1:0] wide;
         if (d == '0) return '1;
         wide = ((2*nsr_pkg::DATA_WIDTH)'(n) << nsr_pkg::FRAC_BITS)
                / (2*nsr_pkg::DATA_WIDTH)'(d);
         if ((wide >> nsr_pkg::DATA_WIDTH) != '0) return '1;
         return wide[nsr_pkg::DATA_WIDTH-1:0];
      endfunction

      function nsr_pkg::rsp_type square_root(nsr_pkg::req_type item);
         logic [nsr_pkg::DATA_WIDTH-1:0] est;
         logic [nsr_pkg::DATA_WIDTH-1:0] next;
         logic [nsr_pkg::DATA_WIDTH-1:0] quot;
         logic [nsr_pkg::DATA_WIDTH-1:0] diff;
         logic [nsr_pkg::DATA_WIDTH:0]   total;
         int                             steps;
         bit                             done;
         nsr_pkg::rsp_type               r;
         r.root       = '0;
         r.status     = nsr_pkg::STATUS_BAD_GUESS;
         r.iterations = '0;
         if (item.initial_guess < nsr_pkg::DATA_WIDTH'(guess_floor)) return r;
         est   = item.initial_guess;
         next  = '0;
         steps = 0;
         done  = 1'b0;
         while (!done) begin
            quot  = scaled_quotient(item.radicand, est);
            total = {1'b0, est} + {1'b0, quot};
            if (total[nsr_pkg::DATA_WIDTH]) total = {1'b0, {nsr_pkg::DATA_WIDTH{1'b1}}};
            next  = total[nsr_pkg::DATA_WIDTH:1];
            steps++;
            diff  = (next >= est) ? next - est : est - next;
            r.status = nsr_pkg::STATUS_SOLVED;
            if (diff <= nsr_pkg::DATA_WIDTH'(tolerance)) done = 1'b1;
            // The cap is tested after convergence, so it wins on the last allowed step.
            if (steps >= int'(iteration_cap)) begin
               r.status = nsr_pkg::STATUS_LIMITED;
               done     = 1'b1;
            end
            est = next;
         end
         r.root       = next;
         r.iterations = nsr_pkg::ITER_W'(steps);
         return r;
      endfunction

      function void note_request(nsr_pkg::req_type item);
         expected_roots.push_back(square_root(item));
      endfunction

      function void flag(string what, logic [63:0] want, logic [63:0] got);
         errors++;
         if (errors <= 10) $display("%0t: %0s mismatch: expected %0h, got %0h",
                                    $realtime, what, want, got);
      endfunction

      function void check_result(nsr_pkg::rsp_type got);
         nsr_pkg::rsp_type want;
         if (expected_roots.size() == 0) begin
            flag("unexpected result, root", '0, 64'(got.root));
            return;
         end
         want = expected_roots.pop_front();
         results_seen++;
         case (want.status)
            nsr_pkg::STATUS_SOLVED:  solved_seen++;
            nsr_pkg::STATUS_LIMITED: limited_seen++;
            default:                 rejected_seen++;
         endcase
         if (got.root !== want.root) flag("root", 64'(want.root), 64'(got.root));
         if (got.status !== want.status)
            flag("status", 64'(want.status), 64'(got.status));
         if (got.iterations !== want.iterations)
            flag("iterations", 64'(want.iterations), 64'(got.iterations));
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   nsr_pkg::req_type               req_data;
   logic                           rsp_valid;
   logic                           rsp_stall;
   nsr_pkg::rsp_type               rsp_data;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [nsr_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [nsr_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [nsr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   sqrt_scoreboard sb;
   int unsigned    idle_pct;
   bit             hold_request;
   int             settings_tried;
   int             cycle_count;

   newton_square_root i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("newton_square_root_tb: done, errors");
      $finish;
   end

   // Both channels are sampled at the edge, before any of this edge's updates land.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_request(req_data);
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // Result side back-pressure: short random bursts, or one long hold-off on request.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(1, 100) <= idle_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_item(input logic [nsr_pkg::DATA_WIDTH-1:0] radicand,
                            input logic [nsr_pkg::DATA_WIDTH-1:0] guess);
      req_data  <= {radicand, guess};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if ($urandom_range(1, 100) <= idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic csr_access(input logic [1:0] index, input bit write,
                             input logic [nsr_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [nsr_pkg::CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= nsr_pkg::CSR_ADDR_W'(index) << 2;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Writes a register, with junk above the field now and then, and reads it back.
   task automatic program_register(input logic [1:0] index,
                                   input logic [nsr_pkg::CSR_DATA_W-1:0] value);
      logic [nsr_pkg::CSR_DATA_W-1:0] data;
      logic [nsr_pkg::CSR_DATA_W-1:0] readback;
      data = value;
      if ($urandom_range(0, 1) == 1) data = data | ($urandom << nsr_pkg::GUESS_W);
      csr_access(index, 1'b1, data, readback);
      sb.write_register(index, data);
      csr_access(index, 1'b0, '0, readback);
      if (readback !== sb.register_value(index))
         sb.flag("register readback", 64'(sb.register_value(index)), 64'(readback));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_roots.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(input logic [nsr_pkg::CSR_DATA_W-1:0] tol,
                            input logic [nsr_pkg::CSR_DATA_W-1:0] cap,
                            input logic [nsr_pkg::CSR_DATA_W-1:0] floor_value,
                            input int unsigned pct,
                            input bit with_hold);
      wait_idle();
      program_register(nsr_pkg::REG_TOLERANCE, tol);
      program_register(nsr_pkg::REG_MAX_ITERATIONS, cap);
      program_register(nsr_pkg::REG_MIN_GUESS, floor_value);
      settings_tried++;
      idle_pct     = pct;
      hold_request = with_hold;
   endtask

   // Mostly guesses near the true root, so that runs converge in a few steps;
   // the rest are unrelated values and the corners of both fields.
   task automatic send_random(input int count);
      logic [nsr_pkg::DATA_WIDTH-1:0] radicand;
      logic [nsr_pkg::DATA_WIDTH-1:0] guess;
      logic [nsr_pkg::DATA_WIDTH-1:0] spread;
      longint                         approx;
      int unsigned                    pick;
      repeat (count) begin
         pick     = $urandom_range(0, 99);
         radicand = $urandom >> $urandom_range(0, 31);
         guess    = $urandom;
         if (pick < 55) begin
            approx = longint'($sqrt(real'(radicand) * 65536.0));
            spread = nsr_pkg::DATA_WIDTH'(approx >> $urandom_range(1, 6));
            approx = approx + longint'($urandom_range(0, spread)) - longint'(spread / 2);
            if (approx < 1) approx = 1;
            guess = nsr_pkg::DATA_WIDTH'(approx);
         end else if (pick < 80) begin
            radicand = $urandom;
         end else if (pick < 90) begin
            guess = $urandom >> $urandom_range(0, 31);
         end else begin
            case ($urandom_range(0, 3))
               0:       radicand = '0;
               1:       radicand = '1;
               2:       radicand = nsr_pkg::DATA_WIDTH'(1);
               default: radicand = nsr_pkg::DATA_WIDTH'(1) << nsr_pkg::FRAC_BITS;
            endcase
            case ($urandom_range(0, 5))
               0:       guess = '0;
               1:       guess = nsr_pkg::DATA_WIDTH'(1);
               2:       guess = '1;
               3:       guess = nsr_pkg::DATA_WIDTH'(sb.guess_floor) - 1;
               4:       guess = nsr_pkg::DATA_WIDTH'(sb.guess_floor);
               default: guess = nsr_pkg::DATA_WIDTH'(1) << nsr_pkg::FRAC_BITS;
            endcase
         end
         send_item(radicand, guess);
      end
   endtask

   initial begin
      logic [nsr_pkg::CSR_DATA_W-1:0] readback;
      sb             = new();
      idle_pct       = 0;
      hold_request   = 1'b0;
      settings_tried = 0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 3; i++) begin
         csr_access(2'(i), 1'b0, '0, readback);
         if (readback !== sb.register_value(2'(i)))
            sb.flag("reset value", 64'(sb.register_value(2'(i))), 64'(readback));
      end

      // Reset settings: zero radicand, rejected zero guess, saturating sums and quotients.
      send_item(32'h0000_0000, 32'h0000_0001);
      send_item(32'h0000_0000, 32'h0000_0000);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(32'hFFFF_FFFF, 32'h0000_0001);
      send_item(32'h0000_0001, 32'hFFFF_FFFF);
      send_item(32'h0001_0000, 32'h0001_0000);
      send_item(32'h0004_0000, 32'h0001_0000);
      send_item(32'h0002_0000, 32'h0001_0000);
      send_item(32'h1234_5678, 32'h0000_4000);
      send_item(32'hFFFF_0000, 32'h00FF_FF00);

      // Exact convergence demanded, widest cap, and a zero estimate allowed.
      configure(32'd0, 32'd63, 32'd0, 20, 1'b0);
      send_item(32'h0005_0000, 32'h0000_0000);
      send_item(32'h0000_0000, 32'h0000_0000);
      send_item(32'hFFFF_FFFF, 32'h0000_0000);
      send_random(25);

      // Loosest tolerance with a single step: convergence on that step still reports the cap.
      configure(32'd65535, 32'd1, 32'd65535, 30, 1'b0);
      send_item(32'h0001_0000, 32'h0001_0000);
      send_item(32'h0001_0000, 32'h0000_FFFE);
      send_item(32'h0001_0000, 32'h0000_FFFF);
      send_random(80);

      // A cap of zero still allows one step.
      configure(32'd1, 32'd0, 32'd1, 10, 1'b0);
      send_item(32'h0009_0000, 32'h0001_0000);
      send_item(32'h0001_0000, 32'h0001_0000);
      send_random(30);

      // The long hold-off lands here while the sender keeps offering.
      configure($urandom_range(0, 255), $urandom_range(4, 20), $urandom_range(0, 1023), 25,
                1'b1);
      send_random(140);

      configure(32'd1, 32'd40, 32'd1, 15, 1'b0);
      send_random(160);

      // Final stretch runs without idling on either side.
      configure($urandom_range(0, 65535), $urandom_range(1, 63), $urandom_range(0, 65535), 0,
                1'b0);
      send_random(100);

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Checked %0d square roots: %0d converged, %0d stopped at the step cap,",
               sb.results_seen, sb.solved_seen, sb.limited_seen);
      $display("%0d guesses rejected; %0d register settings tried, with one long hold-off.",
               sb.rejected_seen, settings_tried + 1);
      if (sb.errors == 0 && sb.expected_roots.size() == 0) begin
         $display("newton_square_root_tb: done, clean");
      end else begin
         $display("newton_square_root_tb: done, errors");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/nsr_pkg.sv
sv/nsr_divider.sv
sv/newton_square_root.sv
sim/newton_square_root_tb.sv
